// ===== src/accel_calibrate_tilt_angles_core_macros.svh =====
// Assertion helpers for the tilt core
`ifndef ACCEL_CALIBRATE_TILT_ANGLES_CORE_MACROS_SVH
`define ACCEL_CALIBRATE_TILT_ANGLES_CORE_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define ACT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define ACT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/act_pkg.sv =====
// ----------------------------------------------------------------------------
// act_pkg
// Types and constants shared by the tilt angle core.
// ----------------------------------------------------------------------------
`default_nettype none
package act_pkg;

  localparam int SampleW = 16;
  localparam int AngleW  = 15;
  localparam int ZW      = 25;
  localparam int TabLen  = 24;

  typedef struct packed {
    logic signed [SampleW-1:0] raw_z;
    logic signed [SampleW-1:0] raw_y;
    logic signed [SampleW-1:0] raw_x;
  } act_in_t;

  typedef struct packed {
    logic                      saturated;
    logic [14:0]               roll_centideg;
    logic [14:0]               pitch_centideg;
    logic signed [SampleW-1:0] cal_z;
    logic signed [SampleW-1:0] cal_y;
    logic signed [SampleW-1:0] cal_x;
  } act_out_t;

  typedef enum logic [2:0] {
    RegGainX  = 3'd0,
    RegGainY  = 3'd1,
    RegGainZ  = 3'd2,
    RegOffset = 3'd3,
    RegBypass = 3'd4
  } act_reg_e;

  function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = 25'sd1152000;  1: v = 25'sd680065;  2: v = 25'sd359328;
      3: v = 25'sd182400;   4: v = 25'sd91554;   5: v = 25'sd45822;
      6: v = 25'sd22916;    7: v = 25'sd11459;   8: v = 25'sd5730;
      9: v = 25'sd2865;     10: v = 25'sd1432;   11: v = 25'sd716;
      12: v = 25'sd358;     13: v = 25'sd179;    14: v = 25'sd90;
      15: v = 25'sd45;      16: v = 25'sd22;     17: v = 25'sd11;
      18: v = 25'sd6;       19: v = 25'sd3;      20: v = 25'sd1;
      21: v = 25'sd1;       default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/accel_calibrate_tilt_angles_core.sv =====
// ----------------------------------------------------------------------------
// accel_calibrate_tilt_angles_core
// Affine accelerometer calibration followed by pitch and roll via CORDIC.
// ----------------------------------------------------------------------------
// Channel  Signals                         Direction
// in       in_valid_i/in_ready_o/in_data_i sample in
// out      out_valid_o/out_ready_i/out_data_o result out
// apb      psel_i..prdata_o                register access
//
// One sample per cycle while the output is not stalled. The stages, in order:
// a multiply stage, a sum stage, one saturate stage, a squared-sum stage, a
// one-bit-a-stage square root of RootW = SampleW+1 stages, then one stage per
// CORDIC step (CORDIC_STEPS, capped at 24) and a final rounding stage. A stall
// at the output freezes the whole pipe (global enable); nothing is lost or
// repeated. Reset clears valid bits and restores the register reset values.
`default_nettype none
module accel_calibrate_tilt_angles_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire act_pkg::act_in_t    in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output act_pkg::act_out_t        out_data_o,
  input  wire logic                psel_i,
  input  wire logic                penable_i,
  input  wire logic                pwrite_i,
  input  wire logic [5:0]          paddr_i,
  input  wire logic [63:0]         pwdata_i,
  output logic [63:0]              prdata_o,
  output logic                     pready_o
);
  import act_pkg::*;
`include "accel_calibrate_tilt_angles_core_macros.svh"

  localparam int SW    = SampleW;
  localparam int SqW   = 2 * SW + 1;          // a^2+b^2
  localparam int RootW = SW + 1;              // sqrt bits
  localparam int CW    = SW + 10;             // CORDIC coordinate width
  localparam int NSt   = (CORDIC_STEPS < TabLen) ? CORDIC_STEPS : TabLen;
  localparam int RemW  = SqW + 2;

  // ---------------- registers -----------------------------------------------
  logic [47:0] gx_q, gy_q, gz_q, off_q;
  logic        byp_q;
  logic        wr;
  logic [2:0]  ridx;

  assign pready_o = 1'b1;
  assign wr       = psel_i & penable_i & pwrite_i;
  assign ridx     = paddr_i[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx_q  <= 48'd16384;
      gy_q  <= 48'd1073741824;
      gz_q  <= 48'd70368744177664;
      off_q <= '0;
      byp_q <= 1'b0;
    end else if (wr && paddr_i[2:0] == 3'd0) begin
      unique case (ridx)
        RegGainX:  gx_q  <= pwdata_i[47:0];
        RegGainY:  gy_q  <= pwdata_i[47:0];
        RegGainZ:  gz_q  <= pwdata_i[47:0];
        RegOffset: off_q <= pwdata_i[47:0];
        RegBypass: byp_q <= pwdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata_o = '0;
    unique case (ridx)
      RegGainX:  prdata_o[47:0] = gx_q;
      RegGainY:  prdata_o[47:0] = gy_q;
      RegGainZ:  prdata_o[47:0] = gz_q;
      RegOffset: prdata_o[47:0] = off_q;
      RegBypass: prdata_o[0]    = byp_q;
      default:   prdata_o       = '0;
    endcase
  end

  // ---------------- global pipe enable --------------------------------------
  logic en;
  assign en         = out_ready_i | ~out_valid_o;
  assign in_ready_o = en;

  localparam int PW  = SW + 17;   // one product
  localparam int AW  = SW + 20;   // sum of products plus offset

  // stage 1: nine products
  logic              v1_q;
  logic signed [PW-1:0] p_q [3][3];
  logic signed [SW-1:0] s1_q [3];
  logic signed [15:0]   o1_q [3];
  logic                 b1_q;
  logic signed [SW-1:0] sin [3];
  logic [47:0]          grow [3];

  assign sin[0] = SW'(in_data_i.raw_x);
  assign sin[1] = SW'(in_data_i.raw_y);
  assign sin[2] = SW'(in_data_i.raw_z);
  assign grow[0] = gx_q;
  assign grow[1] = gy_q;
  assign grow[2] = gz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p_q[r][c] <= PW'($signed(grow[r][16*c +: 16]) * sin[c]);
        end
        s1_q[r] <= sin[r];
        o1_q[r] <= $signed(off_q[16*r +: 16]);
      end
      b1_q <= byp_q;
    end
  end

  // stage 2: sums
  logic                 v2_q, b2_q;
  logic signed [AW-1:0] a2_q [3];
  logic signed [SW-1:0] s2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        a2_q[r] <= AW'(p_q[r][0]) + AW'(p_q[r][1]) + AW'(p_q[r][2])
                 + (AW'(o1_q[r]) <<< 14) + AW'(8192);
        s2_q[r] <= s1_q[r];
      end
      b2_q <= b1_q;
    end
  end

  // stage 3: round, saturate, bypass
  logic                 v3_q, sat3_q;
  logic signed [SW-1:0] c3_q [3];
  logic signed [SW-1:0] cd [3];
  logic                 satd;
  logic signed [AW-15:0] sh [3];

  always_comb begin
    satd = 1'b0;
    for (int r = 0; r < 3; r++) begin
      sh[r] = a2_q[r][AW-1:14];
      if (sh[r] > (AW-14)'((1 <<< (SW-1)) - 1)) begin
        cd[r] = {1'b0, {(SW-1){1'b1}}};
        satd  = 1'b1;
      end else if (sh[r] < -(AW-14)'(1 <<< (SW-1))) begin
        cd[r] = {1'b1, {(SW-1){1'b0}}};
        satd  = 1'b1;
      end else begin
        cd[r] = sh[r][SW-1:0];
      end
      if (b2_q) cd[r] = s2_q[r];
    end
    if (b2_q) satd = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) c3_q[r] <= cd[r];
      sat3_q <= satd;
    end
  end

  // stage 4: squared sums (lane 0 pitch: n=y, a=x,b=z; lane 1 roll: n=x, a=y,b=z)
  localparam int NS = 1 + RootW + NSt + 1;   // stages carrying sideband
  logic [NS-1:0] vq;
  logic signed [SW-1:0] cx_q [NS], cy_q [NS], cz_q [NS];
  logic                 sat_q [NS];
  logic [SqW-1:0] sq_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vq <= '0;
    else if (en) vq <= {vq[NS-2:0], v3_q};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q[0] <= c3_q[0]; cy_q[0] <= c3_q[1]; cz_q[0] <= c3_q[2];
      sat_q[0] <= sat3_q;
      for (int k = 1; k < NS; k++) begin
        cx_q[k] <= cx_q[k-1]; cy_q[k] <= cy_q[k-1]; cz_q[k] <= cz_q[k-1];
        sat_q[k] <= sat_q[k-1];
      end
      sq_q[0] <= SqW'(c3_q[0] * c3_q[0]) + SqW'(c3_q[2] * c3_q[2]);
      sq_q[1] <= SqW'(c3_q[1] * c3_q[1]) + SqW'(c3_q[2] * c3_q[2]);
    end
  end

  // square root: one result bit per stage, MSB first
  logic [SqW-1:0]   rv_q  [2][1:RootW];
  logic [RootW-1:0] rr_q  [2][1:RootW];
  logic [RemW-1:0]  rm_q  [2][1:RootW];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar k = 0; k < RootW; k++) begin : g_sqrt
      localparam int Sh = 2 * (RootW - 1 - k);
      logic [SqW-1:0]   v_in;
      logic [RootW-1:0] r_in;
      logic [RemW-1:0]  m_in;
      logic [RemW-1:0]  rem_n;
      logic [1:0]       pair;
      if (k == 0) begin : g_first
        assign v_in = sq_q[l];
        assign r_in = '0;
        assign m_in = '0;
      end else begin : g_next
        assign v_in = rv_q[l][k];
        assign r_in = rr_q[l][k];
        assign m_in = rm_q[l][k];
      end
      assign pair  = 2'((RemW'(v_in) >> Sh) & RemW'(3));
      assign rem_n = {m_in[RemW-3:0], pair};
      always_ff @(posedge clk_i) begin
        if (en) begin
          rv_q[l][k+1] <= v_in;
          if (rem_n >= RemW'({r_in, 2'b01})) begin
            rm_q[l][k+1] <= rem_n - RemW'({r_in, 2'b01});
            rr_q[l][k+1] <= {r_in[RootW-2:0], 1'b1};
          end else begin
            rm_q[l][k+1] <= rem_n;
            rr_q[l][k+1] <= {r_in[RootW-2:0], 1'b0};
          end
        end
      end
    end

    // CORDIC
    logic signed [CW-1:0] x_q [1:NSt], y_q [1:NSt];
    logic signed [ZW-1:0] z_q [1:NSt];
    logic                 neg_q [1:NSt], zr_q [1:NSt];
    logic signed [CW-1:0] x0, y0;
    logic                 neg0, zr0;
    logic signed [SW-1:0] nsel;
    logic signed [SW:0]   nabs;

    assign nsel = (l == 0) ? cy_q[RootW] : cx_q[RootW];
    assign nabs = -(SW+1)'(nsel);

    always_comb begin
      neg0 = nsel < 0;
      zr0  = rr_q[l][RootW] == '0;
      if (nsel >= 0) begin
        x0 = CW'(nsel) <<< 8;
        y0 = CW'(rr_q[l][RootW]) <<< 8;
      end else begin
        x0 = CW'(rr_q[l][RootW]) <<< 8;
        y0 = CW'(nabs) <<< 8;
      end
    end

    for (genvar i = 0; i < NSt; i++) begin : g_cordic
      logic signed [CW-1:0] xi, yi, xs, ys;
      logic signed [ZW-1:0] zi;
      logic                 negi, zri;
      if (i == 0) begin : g_first
        assign xi   = x0;
        assign yi   = y0;
        assign zi   = '0;
        assign negi = neg0;
        assign zri  = zr0;
      end else begin : g_next
        assign xi   = x_q[i];
        assign yi   = y_q[i];
        assign zi   = z_q[i];
        assign negi = neg_q[i];
        assign zri  = zr_q[i];
      end
      assign xs = xi >>> i;
      assign ys = yi >>> i;
      always_ff @(posedge clk_i) begin
        if (en) begin
          neg_q[i+1] <= negi;
          zr_q[i+1]  <= zri;
          if (yi > 0) begin
            x_q[i+1] <= xi + ys;
            y_q[i+1] <= yi - xs;
            z_q[i+1] <= zi + atan_entry(i);
          end else begin
            x_q[i+1] <= xi - ys;
            y_q[i+1] <= yi + xs;
            z_q[i+1] <= zi - atan_entry(i);
          end
        end
      end
    end

    // final round and special cases; nsel at this stage via sideband
    logic signed [ZW-1:0] zc, zf;
    logic signed [SW-1:0] nfin;
    logic [AngleW-1:0]    ang;
    assign nfin = (l == 0) ? cy_q[RootW+NSt] : cx_q[RootW+NSt];
    always_comb begin
      zc = (z_q[NSt] < 0) ? '0 : z_q[NSt];
      if (neg_q[NSt]) zc = zc + ZW'(9000 * 256);
      zf = (zc + ZW'(128)) >>> 8;
      if (zf > ZW'(18000)) zf = ZW'(18000);
      ang = zf[AngleW-1:0];
      if (zr_q[NSt]) begin
        if (nfin > 0)      ang = '0;
        else if (nfin < 0) ang = AngleW'(18000);
        else               ang = AngleW'(9000);
      end
    end

    logic [AngleW-1:0] ang_q;
    always_ff @(posedge clk_i) begin
      if (en) ang_q <= ang;
    end
  end

  assign out_valid_o              = vq[NS-1];
  assign out_data_o.cal_x          = 16'(cx_q[NS-1]);
  assign out_data_o.cal_y          = 16'(cy_q[NS-1]);
  assign out_data_o.cal_z          = 16'(cz_q[NS-1]);
  assign out_data_o.pitch_centideg = g_lane[0].ang_q;
  assign out_data_o.roll_centideg  = g_lane[1].ang_q;
  assign out_data_o.saturated      = sat_q[NS-1];

  // ---------------- assertions ----------------------------------------------
  `ACT_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o,
    "result dropped under stall")
  `ACT_ASSERT_IMP(a_ang, clk_i, rst_ni, out_valid_o,
    out_data_o.pitch_centideg <= 15'd18000 && out_data_o.roll_centideg <= 15'd18000,
    "angle out of range")
  `ACT_ASSERT_IMP(a_rdy, clk_i, rst_ni, !out_valid_o, in_ready_o,
    "input blocked with empty output")

endmodule
`default_nettype wire

// ===== bench/tb_accel_calibrate_tilt_angles_core.sv =====
// ----------------------------------------------------------------------------
// tb_accel_calibrate_tilt_angles_core
// Drives raw samples through the calibration and tilt core under several
// register settings and random back pressure, predicts every result with an
// independent calibration/CORDIC model and checks it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_accel_calibrate_tilt_angles_core;
  import act_pkg::*;

  localparam int DrainCycles = 60;
  localparam int CycleLimit  = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready_o;
  act_in_t     in_data;
  logic        out_valid_o;
  logic        out_ready;
  act_out_t    out_data_o;
  logic        psel, penable, pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata_o;
  logic        pready_o;

  accel_calibrate_tilt_angles_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .prdata_o   (prdata_o),
    .pready_o   (pready_o)
  );

  // Shadow registers
  logic [47:0] gain_x, gain_y, gain_z, offsets;
  logic        bypass;

  act_in_t  sample_queue[$];
  act_out_t expected_results[$];
  int       send_idle_pct, recv_idle_pct;
  logic     hold_samples;
  int       errors;
  int       cycles;

  longint atan_lut[24] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916,
                           11459, 5730, 2865, 1432, 716, 358, 179, 90, 45,
                           22, 11, 6, 3, 1, 1, 0, 0};

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bits;
    res  = 0;
    bits = 64'd1 << 62;
    while (bits > v) bits = bits >> 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v   = v - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  function automatic logic [14:0] tilt_centideg(longint n, longint a, longint b);
    longint r, x, y, z, xs, ys;
    r = longint'(int_sqrt(longint'(a * a + b * b)));
    if (r == 0) return (n > 0) ? 15'd0 : ((n < 0) ? 15'd18000 : 15'd9000);
    if (n >= 0) begin
      x = n <<< 8;
      y = r <<< 8;
    end else begin
      x = r <<< 8;
      y = (-n) <<< 8;
    end
    z = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + atan_lut[i];
      end else begin
        x = x - ys; y = y + xs; z = z - atan_lut[i];
      end
    end
    if (z < 0) z = 0;
    if (n < 0) z = z + 9000 * 256;
    z = (z + 128) >>> 8;
    if (z > 18000) z = 18000;
    return z[14:0];
  endfunction

  function automatic longint calibrate_axis(logic [47:0] row, logic [15:0] off,
                                            longint sx, longint sy, longint sz,
                                            ref logic sat);
    longint acc;
    acc = longint'($signed(row[15:0])) * sx + longint'($signed(row[31:16])) * sy
        + longint'($signed(row[47:32])) * sz + longint'($signed(off)) * 16384;
    acc = (acc + 8192) >>> 14;
    if (acc > 32767) begin
      sat = 1'b1;
      return 32767;
    end
    if (acc < -32768) begin
      sat = 1'b1;
      return -32768;
    end
    return acc;
  endfunction

  function automatic act_out_t predict_tilt(act_in_t s);
    act_out_t o;
    longint   cx, cy, cz;
    logic     sat;
    sat = 1'b0;
    if (bypass) begin
      cx = s.raw_x; cy = s.raw_y; cz = s.raw_z;
    end else begin
      cx = calibrate_axis(gain_x, offsets[15:0], s.raw_x, s.raw_y, s.raw_z, sat);
      cy = calibrate_axis(gain_y, offsets[31:16], s.raw_x, s.raw_y, s.raw_z, sat);
      cz = calibrate_axis(gain_z, offsets[47:32], s.raw_x, s.raw_y, s.raw_z, sat);
    end
    o.cal_x          = cx[15:0];
    o.cal_y          = cy[15:0];
    o.cal_z          = cz[15:0];
    o.pitch_centideg = tilt_centideg(cy, cx, cz);
    o.roll_centideg  = tilt_centideg(cx, cy, cz);
    o.saturated      = sat;
    return o;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready_o) expected_results.push_back(predict_tilt(in_data));
      if (!in_valid || in_ready_o) begin
        if (sample_queue.size() > 0 && !hold_samples &&
            $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= sample_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("unexpected transaction at cycle %0d", cycles);
          errors++;
        end else begin
          act_out_t want;
          want = expected_results.pop_front();
          if (out_data_o.cal_x !== want.cal_x)
            report_mismatch("cal_x", out_data_o.cal_x, want.cal_x);
          if (out_data_o.cal_y !== want.cal_y)
            report_mismatch("cal_y", out_data_o.cal_y, want.cal_y);
          if (out_data_o.cal_z !== want.cal_z)
            report_mismatch("cal_z", out_data_o.cal_z, want.cal_z);
          if (out_data_o.pitch_centideg !== want.pitch_centideg)
            report_mismatch("pitch", out_data_o.pitch_centideg, want.pitch_centideg);
          if (out_data_o.roll_centideg !== want.roll_centideg)
            report_mismatch("roll", out_data_o.roll_centideg, want.roll_centideg);
          if (out_data_o.saturated !== want.saturated)
            report_mismatch("saturated", out_data_o.saturated, want.saturated);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(act_reg_e idx, logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 6'(idx) << 3;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      RegGainX:  gain_x  = value[47:0];
      RegGainY:  gain_y  = value[47:0];
      RegGainZ:  gain_z  = value[47:0];
      RegOffset: offsets = value[47:0];
      RegBypass: bypass  = value[0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sample_queue.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_all(logic [47:0] gx, logic [47:0] gy, logic [47:0] gz,
                           logic [47:0] off, logic byp);
    write_reg(RegGainX, {16'h0, gx});
    write_reg(RegGainY, {16'h0, gy});
    write_reg(RegGainZ, {16'h0, gz});
    write_reg(RegOffset, {16'h0, off});
    write_reg(RegBypass, {63'h0, byp});
  endtask

  function automatic act_in_t make_sample(int x, int y, int z);
    act_in_t s;
    s.raw_x = x[15:0];
    s.raw_y = y[15:0];
    s.raw_z = z[15:0];
    return s;
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(9))
      0:       return 16'h0;
      1, 2:    return 16'($signed($urandom_range(400)) - 200);
      3:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [15:0] near_unity();
    return 16'(16384 + $signed($urandom_range(2000)) - 1000);
  endfunction

  function automatic logic [15:0] small_gain();
    return 16'($signed($urandom_range(2000)) - 1000);
  endfunction

  initial begin
    act_in_t s;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_samples  = 1'b0;
    errors        = 0;
    cycles        = 0;
    send_idle_pct = 34;
    recv_idle_pct = 56;
    gain_x  = 48'd16384;
    gain_y  = 48'd1073741824;
    gain_z  = 48'd70368744177664;
    offsets = '0;
    bypass  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int setting = 0; setting < 6; setting++) begin
      case (setting / 2)
        0: begin send_idle_pct = 34; recv_idle_pct = 56; end
        1: begin send_idle_pct = 56; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (setting)
        1: write_all({small_gain(), small_gain(), near_unity()},
                     {small_gain(), near_unity(), small_gain()},
                     {near_unity(), small_gain(), small_gain()},
                     {small_gain(), small_gain(), small_gain()}, 1'b0);
        2: write_all(rand48(), rand48(), rand48(), rand48(), 1'b0);
        3: write_all({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, 1'b0);
        4: write_all({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 1'b1);
        5: write_all('0, {3{16'hFFFF}}, {16'h8000, 16'h0, 16'h7FFF},
                     {16'h8000, 16'h7FFF, 16'h8000}, 1'b0);
        default: ;
      endcase

      if (setting == 0) begin
        // zero radius cases, sign of numerator, extremes
        sample_queue.push_back(make_sample(0, 0, 0));
        sample_queue.push_back(make_sample(0, 100, 0));
        sample_queue.push_back(make_sample(0, -100, 0));
        sample_queue.push_back(make_sample(100, 0, 0));
        sample_queue.push_back(make_sample(-100, 0, 0));
        sample_queue.push_back(make_sample(0, 0, 16384));
        sample_queue.push_back(make_sample(0, 0, -16384));
        sample_queue.push_back(make_sample(32767, 32767, 32767));
        sample_queue.push_back(make_sample(-32768, -32768, -32768));
        sample_queue.push_back(make_sample(32767, -32768, 0));
        sample_queue.push_back(make_sample(-32768, 32767, 1));
        sample_queue.push_back(make_sample(1, -1, 1));
        sample_queue.push_back(make_sample(-1, 1, -1));
        sample_queue.push_back(make_sample(5000, -9000, 12000));
        sample_queue.push_back(make_sample(-7000, 3000, -15000));
        sample_queue.push_back(make_sample(16384, 16384, 0));
      end

      for (int n = 0; n < 116; n++) begin
        s.raw_x = rand_axis();
        s.raw_y = rand_axis();
        s.raw_z = rand_axis();
        sample_queue.push_back(s);
        if (setting == 2 && n == 58) begin
          // hold the sender until the pipe has fully drained
          while (sample_queue.size() > 0) @(posedge clk_i);
          hold_samples <= 1'b1;
          @(posedge clk_i);
          while (in_valid || expected_results.size() > 0) @(posedge clk_i);
          hold_samples <= 1'b0;
        end
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
